@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of the IMU frame parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Expression that must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_AT(lbl, clk, rst_n, !(expr), msg)

`endif

@@ hw/rtl/imu_fpy_pkg.sv @@
`timescale 1ns / 1ps
// Package for the IMU frame parser / yaw unwrap block: word types, codes,
// frame layout constants and yaw width helpers. No dependencies.
package imu_fpy_pkg;

    // Yaw accumulator width (24..64); outputs carry its low 32 bits.
    localparam int YAW_W = 32;

    localparam int           FRAME_LEN     = 11;
    localparam logic [3:0]   POS_LAST      = 4'(FRAME_LEN - 1);
    localparam logic [3:0]   POS_TYPE      = 4'd1;
    localparam logic [3:0]   POS_RAW_LO    = 4'd6;
    localparam logic [3:0]   POS_RAW_HI    = 4'd7;
    localparam logic [7:0]   FRAME_HEAD    = 8'h55;
    localparam logic [7:0]   TYPE_GYRO     = 8'h52;
    localparam logic [7:0]   TYPE_ANGLE    = 8'h53;
    localparam logic [7:0]   TICKS_RESET   = 8'd50;
    localparam logic [7:0]   TICKS_MAX     = 8'd255;
    localparam logic [7:0]   TIMEOUT_RESET = 8'd50;

    localparam logic [1:0]   CMD_BYTE      = 2'd0;
    localparam logic [1:0]   CMD_TICK      = 2'd1;
    localparam logic [1:0]   CMD_SET_YAW   = 2'd2;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_ANGLE   = 3'd1,
        ST_GYRO    = 3'd2,
        ST_BAD_SUM = 3'd3,
        ST_OTHER   = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         rx_byte;
        logic signed [31:0] yaw_set_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] yaw_angle;
        logic signed [15:0] gyro_z;
        logic               ready_res;
        logic [31:0]        angle_frame_count;
        logic [2:0]         status;
    } t_out_word;

    // Completed-frame info from the assembler to the yaw tracker.
    typedef struct packed {
        logic        done;
        logic        sum_ok;
        logic [7:0]  kind;
        logic [15:0] raw;
    } t_frame_evt;

    function automatic logic [YAW_W-1:0] ext16_yaw(input logic [15:0] v);
        logic [63:0] w;
        w = {{48{v[15]}}, v};
        return w[YAW_W-1:0];
    endfunction

    function automatic logic [YAW_W-1:0] ext32_yaw(input logic [31:0] v);
        logic [63:0] w;
        w = {{32{v[31]}}, v};
        return w[YAW_W-1:0];
    endfunction

    function automatic logic [31:0] yaw_to_out(input logic [YAW_W-1:0] y);
        logic [63:0] w;
        w = 64'(y);
        return w[31:0];
    endfunction

endpackage

@@ hw/rtl/imu_fpy_frame_asm.sv @@
`timescale 1ns / 1ps
// Frame assembler: header hunt, byte position, running 8-bit checksum and
// capture of the type and raw value bytes. Depends on imu_fpy_pkg.
module imu_fpy_frame_asm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [1:0]             i_cmd,
    input  logic [7:0]             i_byte,
    output imu_fpy_pkg::t_frame_evt o_evt
);
    import imu_fpy_pkg::*;

    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_kind, r_lo, r_hi;
    logic       take, last;

    always_comb begin
        take  = i_adv && (i_cmd == CMD_BYTE) && !((r_pos == 4'd0) && (i_byte != FRAME_HEAD));
        last  = (r_pos == POS_LAST);
        n_pos = r_pos;
        if (take) begin
            n_pos = last ? 4'd0 : r_pos + 4'd1;
        end
        n_sum = (r_pos == 4'd0) ? i_byte : r_sum + i_byte;

        o_evt.done   = take && last;
        o_evt.sum_ok = (r_sum == i_byte);
        o_evt.kind   = r_kind;
        o_evt.raw    = {r_hi, r_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Payload bytes: no reset, always written before a frame completes.
    always_ff @(posedge i_clk) begin
        if (take && !last) begin
            r_sum <= n_sum;
            if (r_pos == POS_TYPE) begin
                r_kind <= i_byte;
            end
            if (r_pos == POS_RAW_LO) begin
                r_lo <= i_byte;
            end
            if (r_pos == POS_RAW_HI) begin
                r_hi <= i_byte;
            end
        end
    end

endmodule

@@ hw/rtl/imu_fpy_yaw_track.sv @@
`timescale 1ns / 1ps
// Yaw tracker: frame dispatch, yaw unwrap and zero, tick timeout, set-yaw,
// gyro latch and frame counter; forms the next result word. Depends on imu_fpy_pkg.
module imu_fpy_yaw_track (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [1:0]              i_cmd,
    input  logic [31:0]             i_set_value,
    input  logic [7:0]              i_timeout,
    input  imu_fpy_pkg::t_frame_evt i_evt,
    output imu_fpy_pkg::t_out_word  o_res
);
    import imu_fpy_pkg::*;

    logic [7:0]       r_ticks, n_ticks;
    logic [15:0]      r_prev, n_prev;
    logic [YAW_W-1:0] r_unw, n_unw;
    logic [YAW_W-1:0] r_zero, n_zero;
    logic [31:0]      r_req, n_req;
    logic             r_have, n_have;
    logic             r_ready, n_ready;
    logic [YAW_W-1:0] r_yaw_out, n_yaw_out;
    logic [15:0]      r_gyro, n_gyro;
    logic [31:0]      r_count, n_count;
    logic [15:0]      diff;
    t_status          status;

    always_comb begin
        n_ticks   = r_ticks;
        n_prev    = r_prev;
        n_unw     = r_unw;
        n_zero    = r_zero;
        n_req     = r_req;
        n_have    = r_have;
        n_ready   = r_ready;
        n_yaw_out = r_yaw_out;
        n_gyro    = r_gyro;
        n_count   = r_count;
        status    = ST_NONE;
        diff      = i_evt.raw - r_prev;

        case (i_cmd)
            CMD_BYTE: begin
                if (i_evt.done) begin
                    if (!i_evt.sum_ok) begin
                        status = ST_BAD_SUM;
                    end else if (i_evt.kind == TYPE_GYRO) begin
                        n_gyro = i_evt.raw;
                        status = ST_GYRO;
                    end else if (i_evt.kind != TYPE_ANGLE) begin
                        status = ST_OTHER;
                    end else begin
                        // first angle frame sets the zero from the pending request
                        if (!r_have) begin
                            n_unw  = ext16_yaw(i_evt.raw);
                            n_zero = n_unw - ext32_yaw(r_req);
                            n_have = 1'b1;
                        end else begin
                            n_unw  = r_unw + ext16_yaw(diff);
                        end
                        n_prev    = i_evt.raw;
                        n_yaw_out = n_unw - n_zero;
                        n_ticks   = 8'd0;
                        n_ready   = 1'b1;
                        n_count   = r_count + 32'd1;
                        status    = ST_ANGLE;
                    end
                end
            end
            CMD_TICK: begin
                if (r_ticks != TICKS_MAX) begin
                    n_ticks = r_ticks + 8'd1;
                end
                if (n_ticks >= i_timeout) begin
                    n_ready = 1'b0;
                    n_gyro  = 16'd0;
                end
            end
            CMD_SET_YAW: begin
                n_req = i_set_value;
                if (r_have) begin
                    n_zero = r_unw - ext32_yaw(i_set_value);
                end
                n_yaw_out = ext32_yaw(i_set_value);
            end
            default: begin
            end
        endcase

        o_res.yaw_angle         = yaw_to_out(n_yaw_out);
        o_res.gyro_z            = n_gyro;
        o_res.ready_res         = n_ready;
        o_res.angle_frame_count = n_count;
        o_res.status            = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= TICKS_RESET;
            r_prev    <= 16'd0;
            r_unw     <= '0;
            r_zero    <= '0;
            r_req     <= 32'd0;
            r_have    <= 1'b0;
            r_ready   <= 1'b0;
            r_yaw_out <= '0;
            r_gyro    <= 16'd0;
            r_count   <= 32'd0;
        end else if (i_adv) begin
            r_ticks   <= n_ticks;
            r_prev    <= n_prev;
            r_unw     <= n_unw;
            r_zero    <= n_zero;
            r_req     <= n_req;
            r_have    <= n_have;
            r_ready   <= n_ready;
            r_yaw_out <= n_yaw_out;
            r_gyro    <= n_gyro;
            r_count   <= n_count;
        end
    end

endmodule

@@ hw/rtl/imu_frame_parser_yaw_unwrap_core.sv @@
`timescale 1ns / 1ps
// Top level of the IMU serial frame parser with yaw unwrap.
// Depends on imu_fpy_pkg, imu_fpy_frame_asm and imu_fpy_yaw_track.
//
// Each input word carries one command: a received serial byte, a timer tick
// or a set-current-yaw request. Bytes are assembled into 11-byte frames that
// start with 0x55 and end in an 8-bit sum checksum; good gyro frames (type
// 0x52) latch the raw Z rate, good angle frames (type 0x53) advance an
// unwrapped yaw accumulator (the first one sets the zero). Every input word
// produces exactly one output word with the current yaw, gyro, ready flag,
// angle frame count and a status code for what the word completed.
// Throughput is one word per clock unless results stall; a word passes the input
// register, then the frame/yaw logic into the result register. The output
// register decouples the sides: a new word is taken while a result waits,
// and o_in_ready follows i_out_ready combinationally when both stages are
// full. The timeout register (reset 50 ticks) is written on the cfg channel,
// which is always ready, and should only be written while the block is idle.
module imu_frame_parser_yaw_unwrap_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  imu_fpy_pkg::t_in_word  i_in_word,
    // result words
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output imu_fpy_pkg::t_out_word o_out_word,
    // timeout register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);
    import imu_fpy_pkg::*;

    logic       r_s1_valid;
    t_in_word   r_s1_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic [7:0] r_timeout;

    logic       s1_adv;
    t_frame_evt evt;
    t_out_word  res;

    // stage 1 moves on when the result register is empty or being drained
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    imu_fpy_frame_asm u_frame_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_cmd   (r_s1_word.command),
        .i_byte  (r_s1_word.rx_byte),
        .o_evt   (evt)
    );

    imu_fpy_yaw_track u_yaw_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_cmd       (r_s1_word.command),
        .i_set_value (r_s1_word.yaw_set_value),
        .i_timeout   (r_timeout),
        .i_evt       (evt),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_word <= i_in_word;
        end
        if (s1_adv) begin
            r_out_word <= res;
        end
    end

endmodule

@@ hw/rtl/imu_fpy_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the IMU frame parser top level, bound in below.
// Depends on imu_fpy_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imu_fpy_port_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input imu_fpy_pkg::t_out_word o_out_word
);
    import imu_fpy_pkg::*;

    // a stalled result word holds
    `ASSERT_AT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "result word changed while stalled")
    // status codes stay in range
    `ASSERT_NEVER(a_status_range, i_clk, i_rst_n, o_out_valid && (o_out_word.status > ST_OTHER), "bad status code")
    // an angle frame always leaves ready set
    `ASSERT_AT(a_angle_ready, i_clk, i_rst_n, o_out_valid && (o_out_word.status == ST_ANGLE) |-> o_out_word.ready_res, "angle frame without ready")
    // nothing pending right after reset
    `ASSERT_AT(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_out_valid && o_in_ready, "pipeline not empty after reset")

endmodule

bind imu_frame_parser_yaw_unwrap_core imu_fpy_port_checker u_imu_fpy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

@@ dv/imu_fpy_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the IMU frame parser / yaw unwrap core: tracks the block's state
// from accepted input words and checks every accepted result word against it.
// Depends on imu_fpy_pkg.
module imu_fpy_checker
    import imu_fpy_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    // shadow of the parser and yaw tracker
    logic [7:0]       frame_buf [FRAME_LEN];
    logic [3:0]       fill_pos;
    logic [7:0]       idle_ticks;
    logic [7:0]       timeout_copy;
    logic [15:0]      last_raw;
    logic [YAW_W-1:0] yaw_acc;
    logic [YAW_W-1:0] yaw_zero;
    logic [YAW_W-1:0] yaw_shown;
    logic [31:0]      yaw_request;
    logic             angle_seen;
    logic             ready_held;
    logic [15:0]      gyro_held;
    logic [31:0]      angle_frames;

    t_out_word        due_reports [$];

    task automatic track_word(input t_in_word w, output t_out_word r);
        logic [7:0]              sum;
        logic [15:0]             raw;
        logic signed [YAW_W-1:0] ext;
        logic [63:0]             wide;
        t_status                 code;
        code = ST_NONE;
        case (w.command)
            CMD_BYTE: begin
                // nothing is taken until a header byte opens a frame
                if (!(fill_pos == 0 && w.rx_byte != FRAME_HEAD)) begin
                    frame_buf[fill_pos] = w.rx_byte;
                    fill_pos++;
                    if (fill_pos >= FRAME_LEN) begin
                        fill_pos = '0;
                        sum = '0;
                        for (int i = 0; i < FRAME_LEN - 1; i++)
                            sum += frame_buf[i];
                        raw = {frame_buf[POS_RAW_HI], frame_buf[POS_RAW_LO]};
                        if (sum != frame_buf[POS_LAST]) begin
                            code = ST_BAD_SUM;
                        end else if (frame_buf[POS_TYPE] == TYPE_GYRO) begin
                            gyro_held = raw;
                            code = ST_GYRO;
                        end else if (frame_buf[POS_TYPE] != TYPE_ANGLE) begin
                            code = ST_OTHER;
                        end else begin
                            if (!angle_seen) begin
                                // first angle frame pins the zero to the pending request
                                ext = $signed(raw);
                                yaw_acc = ext;
                                ext = $signed(yaw_request);
                                yaw_zero = yaw_acc - ext;
                                angle_seen = 1'b1;
                            end else begin
                                // 16-bit wrapped step; +180 deg ties to -180
                                ext = $signed(16'(raw - last_raw));
                                yaw_acc = yaw_acc + ext;
                            end
                            last_raw = raw;
                            yaw_shown = yaw_acc - yaw_zero;
                            idle_ticks = '0;
                            ready_held = 1'b1;
                            angle_frames++;
                            code = ST_ANGLE;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (idle_ticks != TICKS_MAX)
                    idle_ticks++;
                if (idle_ticks >= timeout_copy) begin
                    ready_held = 1'b0;
                    gyro_held = '0;
                end
            end
            CMD_SET_YAW: begin
                yaw_request = w.yaw_set_value;
                ext = $signed(w.yaw_set_value);
                if (angle_seen)
                    yaw_zero = yaw_acc - ext;
                yaw_shown = ext;
            end
            default: ;
        endcase
        wide = 64'(yaw_shown);
        r.yaw_angle = wide[31:0];
        r.gyro_z = gyro_held;
        r.ready_res = ready_held;
        r.angle_frame_count = angle_frames;
        r.status = code;
    endtask

    function automatic int field_bad(input string name, input logic signed [63:0] want,
                                     input logic signed [63:0] got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word got;
        t_out_word made;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            fill_pos = '0;
            idle_ticks = TICKS_RESET;
            timeout_copy = TIMEOUT_RESET;
            last_raw = '0;
            yaw_acc = '0;
            yaw_zero = '0;
            yaw_shown = '0;
            yaw_request = '0;
            angle_seen = 1'b0;
            ready_held = 1'b0;
            gyro_held = '0;
            angle_frames = '0;
            due_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                timeout_copy = i_cfg_data;
            // results first: a word accepted now cannot have its result out yet
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                if (due_reports.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %h", $time, got);
                    errs++;
                end else begin
                    want = due_reports.pop_front();
                    errs += field_bad("yaw_angle", want.yaw_angle, got.yaw_angle);
                    errs += field_bad("gyro_z", want.gyro_z, got.gyro_z);
                    errs += field_bad("ready_res", want.ready_res, got.ready_res);
                    errs += field_bad("angle_frame_count", want.angle_frame_count,
                                      got.angle_frame_count);
                    errs += field_bad("status", want.status, got.status);
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_word(i_in_word, made);
                due_reports.push_back(made);
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending <= due_reports.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the IMU frame parser / yaw unwrap testbench: clock, reset, stimulus and verdict.
// Depends on imu_fpy_pkg, imu_fpy_checker and the core under test.
module testbench;
    import imu_fpy_pkg::*;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         PHASES = 6;
    localparam int         WORDS_PER_PHASE = 130;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    int         fail_count;
    int         words_pending;
    int         sent_words = 0;
    logic [7:0] cur_timeout = TIMEOUT_RESET;
    logic [15:0] heading = '0;

    imu_frame_parser_yaw_unwrap_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // scoreboard sits beside the core and only watches the handshakes
    imu_fpy_checker watcher (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // hard stop in case the core wedges; far beyond the slowest legal run
    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // idle length shared by both sides: mostly none or short, rarely long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // set-yaw values lean on the 32-bit extremes
    function automatic logic [31:0] pick_yaw();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result side: ready bursts broken by random stalls, with calm stretches.
    initial begin : result_sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = pick_gap($urandom_range(0, 9) == 0);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // One input word. Called at a clock edge; returns at the edge that accepts it.
    // Valid is only dropped when a gap is taken, so it never toggles within a step.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [31:0] setv);
        int gap;
        // every third run of 64 words goes without sender gaps
        gap = pick_gap(((sent_words / 64) % 3) == 2);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{command: cmd, rx_byte: b, yaw_set_value: setv};
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent_words++;
    endtask

    // Full 11-byte frame; filler bytes random. A bad sum flips checksum bits.
    // Mixed frames get ticks and set-yaw words slipped between the bytes.
    task automatic send_frame(input logic [7:0] kind, input logic [15:0] raw,
                              input bit bad_sum, input bit mixed);
        logic [7:0] bytes [FRAME_LEN];
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            case (i)
                0: bytes[i] = FRAME_HEAD;
                1: bytes[i] = kind;
                6: bytes[i] = raw[7:0];
                7: bytes[i] = raw[15:8];
                default: bytes[i] = 8'($urandom);
            endcase
            sum += bytes[i];
        end
        bytes[FRAME_LEN-1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (mixed && $urandom_range(0, 15) == 0)
                send_word($urandom_range(0, 1) ? CMD_TICK : CMD_SET_YAW, 8'($urandom),
                          pick_yaw());
            send_word(CMD_BYTE, bytes[i], $urandom);
        end
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_word(CMD_TICK, 8'($urandom), $urandom);
    endtask

    // Stop sending and let every expected result drain out, plus pipeline slack.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Timeout register write; only issued while the core is idle.
    task automatic write_timeout(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cur_timeout = v;
        @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0]  timeout_plan [PHASES];
        logic [7:0]  kind;
        logic [15:0] raw;
        int          phase_end;
        int          r;
        int          n;
        // first phase runs on the reset timeout, no write; then short, max, zero, one, random
        timeout_plan = '{TIMEOUT_RESET, 8'd4, 8'd255, 8'd0, 8'd1, 8'd0};
        timeout_plan[PHASES-1] = 8'($urandom_range(2, 40));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // junk before any header is dropped; extremes of the byte field
        send_word(CMD_BYTE, 8'h00, 32'h0000_0000);
        send_word(CMD_BYTE, 8'hFF, 32'hFFFF_FFFF);
        // unused command changes nothing
        send_word(CMD_UNUSED, 8'hAA, 32'h5555_5555);
        send_word(CMD_TICK, 8'h55, 32'h0);
        // set-yaw before any angle: only stored, shown on the yaw output
        send_word(CMD_SET_YAW, 8'h00, 32'h7FFF_FFFF);
        // first angle frame sets the zero so the yaw reads the stored request
        send_frame(TYPE_ANGLE, 16'h7FFF, 1'b0, 1'b0);
        // +1 step pushes the shown yaw over the 32-bit top
        send_frame(TYPE_ANGLE, 16'h8000, 1'b0, 1'b0);
        // exact half-turn step wraps to -180 deg
        send_frame(TYPE_ANGLE, 16'h0000, 1'b0, 1'b0);
        send_frame(TYPE_GYRO, 16'h8000, 1'b0, 1'b0);
        send_frame(TYPE_GYRO, 16'h7FFF, 1'b0, 1'b0);
        send_frame(TYPE_ANGLE, 16'h1234, 1'b1, 1'b0);
        send_frame(8'h51, 16'h4321, 1'b0, 1'b0);
        send_word(CMD_SET_YAW, 8'hFF, 32'h8000_0000);
        send_word(CMD_SET_YAW, 8'h00, 32'h0000_0000);
        // run the idle tick count past the timeout: ready and gyro clear
        tick_run(TIMEOUT_RESET + 2);

        // ---- random part, one phase per timeout setting ----
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_timeout(timeout_plan[p]);
            end
            phase_end = sent_words + WORDS_PER_PHASE;
            while (sent_words < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    // angle frames walk the heading: small steps, big jumps, half turns
                    case ($urandom_range(0, 7))
                        0: heading = heading + 16'h8000;
                        1: heading = 16'($urandom);
                        2: heading = heading + 16'h7FFF;
                        default: heading = heading + 16'($urandom_range(0, 800)) - 16'd400;
                    endcase
                    send_frame(TYPE_ANGLE, heading, 1'b0, r < 8);
                end else if (r < 58) begin
                    case ($urandom_range(0, 5))
                        0: raw = 16'h8000;
                        1: raw = 16'h7FFF;
                        default: raw = 16'($urandom);
                    endcase
                    send_frame(TYPE_GYRO, raw, 1'b0, r < 46);
                end else if (r < 63) begin
                    send_frame(8'($urandom), 16'($urandom), 1'b0, 1'b0);
                end else if (r < 70) begin
                    kind = $urandom_range(0, 1) ? TYPE_ANGLE : TYPE_GYRO;
                    send_frame(kind, 16'($urandom), 1'b1, 1'b0);
                end else if (r < 74) begin
                    // broken frame or line noise, then zeros to fall back to the header hunt
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        send_word(CMD_BYTE, (i == 0 && $urandom_range(0, 1)) ?
                                  FRAME_HEAD : 8'($urandom), $urandom);
                    repeat (FRAME_LEN - 1) send_word(CMD_BYTE, 8'h00, $urandom);
                end else if (r < 88) begin
                    // mostly short tick runs; some run right up to and past the timeout
                    if ($urandom_range(0, 9) == 0)
                        tick_run(int'(cur_timeout) + $urandom_range(1, 3));
                    else
                        tick_run($urandom_range(1, 6));
                end else if (r < 96) begin
                    send_word(CMD_SET_YAW, 8'($urandom), pick_yaw());
                end else begin
                    send_word(CMD_UNUSED, 8'($urandom), pick_yaw());
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
